/* hw/rtl/vnab_pkg.sv */
// Shared types, constants and divider step function for the voxel address unit.
`default_nettype none
package vnab_pkg;

  localparam int AXES           = 3;
  localparam int COORD_W        = 24;
  localparam int FRAC_W         = 8;
  localparam int START_W        = 16;
  localparam int SIZE_W         = 11;
  localparam int IDX_W          = COORD_W - FRAC_W + 2;
  localparam int ADDR_W         = 32;
  localparam int COMP_W         = 2;
  localparam int MODE_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MUL1_W         = 2 * SIZE_W + 1;
  localparam int COMPONENTS_DEF = 1;

  // Divider: one remainder bit per step, a few steps per stage.
  localparam int DIV_W          = IDX_W;
  localparam int DIV_STEPS_PER  = 3;
  localparam int DIV_STAGES     = DIV_W / DIV_STEPS_PER;

  typedef enum logic [MODE_W-1:0] {
    MODE_BACKGROUND = 3'd0,
    MODE_WRAP       = 3'd1,
    MODE_MIRROR     = 3'd2,
    MODE_BORDER     = 3'd3,
    MODE_NONE       = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_OVERWRITE = 3'd1,
    CFG_SIZE_X    = 3'd2,
    CFG_SIZE_Y    = 3'd3,
    CFG_SIZE_Z    = 3'd4,
    CFG_START_X   = 3'd5,
    CFG_START_Y   = 3'd6,
    CFG_START_Z   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_BG   = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FOLD_PASS   = 2'd0,
    FOLD_WRAP   = 2'd1,
    FOLD_MIRROR = 2'd2
  } fold_t;

  typedef struct packed {
    logic [MODE_W-1:0]                   mode;
    logic                                overwrite;
    logic [AXES-1:0][SIZE_W-1:0]         size;   // already forced to at least 1
    logic [AXES-1:0][START_W-1:0]        start;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0]  dvd;
    logic [SIZE_W-1:0] rem;
    logic              qlsb;
    logic [SIZE_W-1:0] dvs;
    logic              neg;
    logic [SIZE_W-1:0] idx;
  } div_ax_t;

  typedef struct packed {
    kind_t                  kind;
    fold_t                  fold;
    div_ax_t [AXES-1:0]     ax;
  } pipe_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] base;
  } back_t;

  // Advance one axis by DIV_STEPS_PER restoring division steps.
  function automatic div_ax_t div_steps(input div_ax_t a);
    div_ax_t         o;
    logic [SIZE_W:0] rr;
    o = a;
    for (int i = 0; i < DIV_STEPS_PER; i++) begin
      rr    = {o.rem, o.dvd[DIV_W-1]};
      o.dvd = {o.dvd[DIV_W-2:0], 1'b0};
      if (rr >= {1'b0, o.dvs}) begin
        rr     = rr - {1'b0, o.dvs};
        o.qlsb = 1'b1;
      end else begin
        o.qlsb = 1'b0;
      end
      o.rem = rr[SIZE_W-1:0];
    end
    return o;
  endfunction

  function automatic pipe_t pipe_step(input pipe_t p);
    pipe_t o;
    o = p;
    for (int a = 0; a < AXES; a++) begin
      o.ax[a] = div_steps(p.ax[a]);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/vnab_front.sv */
// Front stages: rounding, extent offset, range test and divider set-up.
`default_nettype none
module vnab_front
  import vnab_pkg::*;
(
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              in_valid,
  input  wire logic [AXES-1:0][COORD_W-1:0]      coord,
  input  wire cfg_t                              cfg,
  output logic                                   out_valid,
  output pipe_t                                  out_pipe
);

  localparam int RND_W = COORD_W - FRAC_W + 1;

  logic                     s1_valid_r;
  logic signed [IDX_W-1:0]  s1_n_r [AXES];
  logic signed [IDX_W-1:0]  n_nxt  [AXES];
  logic                     s2_valid_r;
  pipe_t                    s2_r;
  pipe_t                    s2_nxt;

  always_comb begin
    logic signed [COORD_W:0]  cs;
    logic        [RND_W-1:0]  rnd;
    logic        [START_W-1:0] st;
    for (int a = 0; a < AXES; a++) begin
      cs       = $signed({coord[a][COORD_W-1], coord[a]}) +
                 $signed((COORD_W+1)'(1 << (FRAC_W - 1)));
      rnd      = cs[COORD_W:FRAC_W];
      st       = cfg.start[a];
      n_nxt[a] = $signed({rnd[RND_W-1], rnd}) -
                 $signed({{(IDX_W-START_W){st[START_W-1]}}, st});
    end
  end

  always_comb begin
    logic outside;
    logic neg;
    outside = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (s1_n_r[a] < 0 || s1_n_r[a] >= $signed(IDX_W'(cfg.size[a]))) begin
        outside = 1'b1;
      end
    end
    s2_nxt.kind = KIND_HIT;
    s2_nxt.fold = FOLD_PASS;
    if (outside) begin
      if (cfg.mode == MODE_WRAP) begin
        s2_nxt.fold = FOLD_WRAP;
      end else if (cfg.mode == MODE_MIRROR) begin
        s2_nxt.fold = FOLD_MIRROR;
      end else if (cfg.mode == MODE_BACKGROUND || cfg.mode == MODE_BORDER) begin
        s2_nxt.kind = KIND_BG;
      end else begin
        s2_nxt.kind = KIND_NONE;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      neg                  = s1_n_r[a][IDX_W-1];
      s2_nxt.ax[a].neg     = neg;
      s2_nxt.ax[a].rem     = '0;
      s2_nxt.ax[a].qlsb    = 1'b0;
      s2_nxt.ax[a].dvs     = cfg.size[a];
      s2_nxt.ax[a].idx     = s1_n_r[a][SIZE_W-1:0];
      // Mirror folds n<0 onto -n-1; wrap works on the magnitude.
      if (s2_nxt.fold == FOLD_MIRROR) begin
        s2_nxt.ax[a].dvd = neg ? ~s1_n_r[a] : s1_n_r[a];
      end else begin
        s2_nxt.ax[a].dvd = neg ? -s1_n_r[a] : s1_n_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        s1_n_r[a] <= n_nxt[a];
      end
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_pipe  = s2_r;

endmodule
`default_nettype wire

/* hw/rtl/vnab_div_pipe.sv */
// Pipelined restoring divider producing remainder and quotient parity per axis.
`default_nettype none
module vnab_div_pipe
  import vnab_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire pipe_t  in_pipe,
  output logic        out_valid,
  output pipe_t       out_pipe
);

  logic  stg_valid_r [DIV_STAGES];
  pipe_t stg_r       [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stg_valid_r[s] <= 1'b0;
      end
    end else if (adv) begin
      stg_valid_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        stg_valid_r[s] <= stg_valid_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= pipe_step(in_pipe);
      for (int s = 1; s < DIV_STAGES; s++) begin
        stg_r[s] <= pipe_step(stg_r[s-1]);
      end
    end
  end

  assign out_valid = stg_valid_r[DIV_STAGES-1];
  assign out_pipe  = stg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

/* hw/rtl/vnab_back.sv */
// Back stages: index fold-back and linear base address in two multiply steps.
`default_nettype none
module vnab_back
  import vnab_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire pipe_t  in_pipe,
  input  wire cfg_t   cfg,
  output logic        out_valid,
  output back_t       out_back
);

  logic              fix_valid_r;
  kind_t             fix_kind_r;
  logic [SIZE_W-1:0] fix_idx_r [AXES];
  logic [SIZE_W-1:0] idx_nxt   [AXES];
  logic              m1_valid_r;
  kind_t             m1_kind_r;
  logic [MUL1_W-1:0] m1_t_r;
  logic [SIZE_W-1:0] m1_ix_r;
  logic [MUL1_W-1:0] t_nxt;
  logic              m2_valid_r;
  back_t             m2_r;
  logic [ADDR_W-1:0] base_nxt;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      case (in_pipe.fold)
        FOLD_WRAP: begin
          idx_nxt[a] = (in_pipe.ax[a].neg && in_pipe.ax[a].rem != '0) ?
                       in_pipe.ax[a].dvs - in_pipe.ax[a].rem : in_pipe.ax[a].rem;
        end
        FOLD_MIRROR: begin
          idx_nxt[a] = in_pipe.ax[a].qlsb ?
                       in_pipe.ax[a].dvs - in_pipe.ax[a].rem - SIZE_W'(1) :
                       in_pipe.ax[a].rem;
        end
        default: begin
          idx_nxt[a] = in_pipe.ax[a].idx;
        end
      endcase
    end
  end

  assign t_nxt    = MUL1_W'(fix_idx_r[2]) * MUL1_W'(cfg.size[1]) + MUL1_W'(fix_idx_r[1]);
  assign base_nxt = ADDR_W'(m1_t_r) * ADDR_W'(cfg.size[0]) + ADDR_W'(m1_ix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_valid_r <= 1'b0;
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
    end else if (adv) begin
      fix_valid_r <= in_valid;
      m1_valid_r  <= fix_valid_r;
      m2_valid_r  <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fix_kind_r <= in_pipe.kind;
      for (int a = 0; a < AXES; a++) begin
        fix_idx_r[a] <= idx_nxt[a];
      end
      m1_kind_r    <= fix_kind_r;
      m1_t_r       <= t_nxt;
      m1_ix_r      <= fix_idx_r[0];
      m2_r.kind    <= m1_kind_r;
      m2_r.base    <= base_nxt;
    end
  end

  assign out_valid = m2_valid_r;
  assign out_back  = m2_r;

endmodule
`default_nettype wire

/* hw/rtl/voxel_nearest_address_with_boundary_unit.sv */
// Top level: configuration registers, address pipeline and per-component result emitter.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------------
//  input    | in_coord_x/y/z                          | taken when start=1 and busy=0
//  result   | out_address, out_component, out_*       | out_valid strobe, one cycle, no stall
//  config   | cfg_index, cfg_data                     | cfg_valid/cfg_ready, ready always 1
//
// From acceptance to its first result an item passes rounding, range test, the
// six-stage divider that folds indices for wrap and mirror, fold-back, two multiply
// stages and the emitter register.
// Each item gives COMPONENTS results (one for do-nothing), one per cycle; the emitter
// raises busy and freezes the whole pipeline while it still has results to send.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults.
`default_nettype none
module voxel_nearest_address_with_boundary_unit
  import vnab_pkg::*;
#(
  parameter int unsigned COMPONENTS = COMPONENTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic signed [COORD_W-1:0] in_coord_z,
  output logic                           out_valid,
  output logic [ADDR_W-1:0]              out_address,
  output logic [COMP_W-1:0]              out_component,
  output logic                           out_use_background,
  output logic                           out_no_action,
  output logic                           out_write_volume,
  output logic                           out_hit,
  output logic                           out_last,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic [MODE_W-1:0]  mode_r;
  logic               overwrite_r;
  logic [SIZE_W-1:0]  size_r  [AXES];
  logic [START_W-1:0] start_r [AXES];
  cfg_t               cfg;

  // Pipeline links
  logic               adv;
  logic               in_valid;
  logic               fr_valid;
  pipe_t              fr_pipe;
  logic               dv_valid;
  pipe_t              dv_pipe;
  logic               bk_valid;
  back_t              bk_back;

  // Emitter
  logic               em_valid_r;
  kind_t              em_kind_r;
  logic [ADDR_W-1:0]  em_base_r;
  logic [COMP_W-1:0]  em_comp_r;
  logic [COMP_W-1:0]  em_comp_nxt;
  logic               em_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BACKGROUND;
      overwrite_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        size_r[a]  <= SIZE_W'(1);
        start_r[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        CFG_OVERWRITE: overwrite_r <= cfg_data[0];
        CFG_SIZE_X:    size_r[0]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:    size_r[1]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:    size_r[2]   <= cfg_data[SIZE_W-1:0];
        CFG_START_X:   start_r[0]  <= cfg_data[START_W-1:0];
        CFG_START_Y:   start_r[1]  <= cfg_data[START_W-1:0];
        CFG_START_Z:   start_r[2]  <= cfg_data[START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A size of zero behaves as one.
  always_comb begin
    cfg.mode      = mode_r;
    cfg.overwrite = overwrite_r;
    for (int a = 0; a < AXES; a++) begin
      cfg.size[a]  = (size_r[a] == '0) ? SIZE_W'(1) : size_r[a];
      cfg.start[a] = start_r[a];
    end
  end

  // Advance everything unless the emitter still owes results for its item.
  assign em_last  = (em_kind_r == KIND_NONE) || (em_comp_r == COMP_W'(COMPONENTS - 1));
  assign adv      = !em_valid_r || em_last;
  assign busy     = !adv;
  assign in_valid = start && !busy;

  vnab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .coord     ({in_coord_z, in_coord_y, in_coord_x}),
    .cfg       (cfg),
    .out_valid (fr_valid),
    .out_pipe  (fr_pipe)
  );

  vnab_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_pipe   (fr_pipe),
    .out_valid (dv_valid),
    .out_pipe  (dv_pipe)
  );

  vnab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv_valid),
    .in_pipe   (dv_pipe),
    .cfg       (cfg),
    .out_valid (bk_valid),
    .out_back  (bk_back)
  );

  // Load a fresh item on advance, otherwise step to the next component.
  assign em_comp_nxt = adv ? '0 : em_comp_r + COMP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else if (adv) begin
      em_valid_r <= bk_valid;
    end
  end

  always_ff @(posedge clk) begin
    em_comp_r <= em_comp_nxt;
    if (adv) begin
      em_kind_r <= bk_back.kind;
      em_base_r <= bk_back.base;
    end
  end

  always_comb begin
    out_valid          = em_valid_r;
    out_component      = '0;
    out_address        = '0;
    out_use_background = 1'b0;
    out_no_action      = 1'b0;
    out_write_volume   = 1'b0;
    out_hit            = 1'b0;
    out_last           = em_last;
    case (em_kind_r)
      KIND_HIT: begin
        out_component    = em_comp_r;
        out_address      = em_base_r * ADDR_W'(COMPONENTS) + ADDR_W'(em_comp_r);
        out_write_volume = overwrite_r;
        out_hit          = 1'b1;
      end
      KIND_BG: begin
        out_component      = em_comp_r;
        out_use_background = 1'b1;
      end
      KIND_NONE: begin
        out_no_action = 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_more_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("more results pending but input not held off");

  a_comp_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_component == $past(out_component) + 2'd1)
    else $error("component sequence broken");

  a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_action |-> out_last && !out_hit && !out_use_background)
    else $error("no-action result malformed");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_use_background))
    else $error("hit and background both set");
`endif

endmodule
`default_nettype wire
